// File: rtl/core/lag_pkg.sv
// Shared types, widths and codes for the life automaton generation block.
// Used by life_automaton_generation and lag_row_update; depends on nothing.
package lag_pkg;

  // Default grid size.
  localparam int LAG_MAX_ROWS    = 64;
  localparam int LAG_MAX_COLUMNS = 64;

  // Field widths.
  localparam int OP_W        = 2;
  localparam int ROW_W       = 6;
  localparam int COL_W       = 6;
  localparam int SIZE_W      = 7;
  localparam int RULE_W      = 4;
  localparam int COUNT_W     = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 7;

  // Command codes. Any code other than toggle or generation reads the cell.
  localparam logic [OP_W-1:0] OP_TOGGLE = 2'd0;
  localparam logic [OP_W-1:0] OP_GEN    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_ROWS    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_COLUMNS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BIRTH_COUNT    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SURVIVE_MIN    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SURVIVE_MAX    = 3'd4;

  // Register values after reset.
  localparam logic [SIZE_W-1:0] RST_ACTIVE_ROWS    = 7'd64;
  localparam logic [SIZE_W-1:0] RST_ACTIVE_COLUMNS = 7'd64;
  localparam logic [RULE_W-1:0] RST_BIRTH_COUNT    = 4'd3;
  localparam logic [RULE_W-1:0] RST_SURVIVE_MIN    = 4'd2;
  localparam logic [RULE_W-1:0] RST_SURVIVE_MAX    = 4'd3;

  // One command transfer.
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
  } cmd_t;

  // One result transfer.
  typedef struct packed {
    logic cell_alive;
    logic stable;
    logic out_of_range;
  } result_t;

  // Birth and survival rule handed to the row update logic.
  typedef struct packed {
    logic [RULE_W-1:0] birth_count;
    logic [RULE_W-1:0] survive_min;
    logic [RULE_W-1:0] survive_max;
  } rule_t;

endpackage

// File: rtl/core/life_automaton_generation.sv
// Top level of the life automaton: configuration, command sequencer and row memory.
// Depends on lag_pkg and instantiates lag_row_update.
//
//   channel   ports                               transfer at rising edge when
//   command   start, busy, cmd                    start && !busy
//   result    done, result                        done (one cycle, no back pressure)
//   config    cfg_write, cfg_index, cfg_data      cfg_write
//
// Toggle and read pass through a registered memory read and the access state, where a toggle
// writes the row back; an address outside the active area answers straight from idle.
// A generation sweeps the row memory once, one row read and one row written per cycle,
// over the rows in use (active_rows, zero as one, capped).
// Reset clears the per-row valid bits at once, so the grid reads as all dead.
// Writing active_columns starts a clearing sweep over all MAX_ROWS rows with busy high.
// Results cannot be held off by the receiver; the block never stalls on its output.
module life_automaton_generation
  import lag_pkg::*;
#(
  parameter int MAX_ROWS    = LAG_MAX_ROWS,
  parameter int MAX_COLUMNS = LAG_MAX_COLUMNS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  cmd_t                   cmd,
  output logic                   busy,
  output logic                   done,
  output result_t                result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int NRW = $clog2(MAX_ROWS + 1);
  localparam int NCW = $clog2(MAX_COLUMNS + 1);
  localparam int GW  = $clog2(MAX_ROWS + 2);
  localparam int SRW = (NRW > SIZE_W) ? NRW : SIZE_W;
  localparam int SCW = (NCW > SIZE_W) ? NCW : SIZE_W;
  localparam int RAW = (NRW > ROW_W) ? NRW : ROW_W;
  localparam int CAW = (NCW > COL_W) ? NCW : COL_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ACCESS = 4'b0010,
    ST_GEN    = 4'b0100,
    ST_CLEAR  = 4'b1000
  } state_t;

  // Size register value to rows in use: zero acts as one, large values saturate.
  function automatic logic [NRW-1:0] eff_rows_f(input logic [SIZE_W-1:0] v);
    logic [SRW-1:0] ext;
    ext = SRW'(v);
    if (v == '0) begin
      return NRW'(1);
    end else if (ext > SRW'(MAX_ROWS)) begin
      return NRW'(MAX_ROWS);
    end else begin
      return NRW'(ext);
    end
  endfunction

  function automatic logic [NCW-1:0] eff_cols_f(input logic [SIZE_W-1:0] v);
    logic [SCW-1:0] ext;
    ext = SCW'(v);
    if (v == '0) begin
      return NCW'(1);
    end else if (ext > SCW'(MAX_COLUMNS)) begin
      return NCW'(MAX_COLUMNS);
    end else begin
      return NCW'(ext);
    end
  endfunction

  function automatic logic [MAX_COLUMNS-1:0] col_mask_f(input logic [NCW-1:0] nc);
    logic [MAX_COLUMNS-1:0] m;
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      m[c] = (NCW'(c) < nc);
    end
    return m;
  endfunction

  // Configuration registers.
  logic [SIZE_W-1:0] active_rows;
  logic [SIZE_W-1:0] active_columns;
  rule_t             rule;

  // Sequencer state.
  state_t                 state;
  logic [GW-1:0]          gen_cnt;
  logic                   same;
  logic [MAX_COLUMNS-1:0] sweep_mask;
  logic [OP_W-1:0]        op_q;
  logic [RW-1:0]          row_q;
  logic [CW-1:0]          col_q;
  logic [MAX_COLUMNS-1:0] above_row;
  logic [MAX_COLUMNS-1:0] current_row;

  // Row memory and its per-row valid bits.
  logic [MAX_COLUMNS-1:0] grid_mem [MAX_ROWS];
  logic [MAX_ROWS-1:0]    row_valid;
  logic [MAX_ROWS-1:0]    row_valid_next;
  logic                   rd_en;
  logic [RW-1:0]          rd_addr;
  logic [MAX_COLUMNS-1:0] rd_data;
  logic                   rd_ok;
  logic [MAX_COLUMNS-1:0] rd_row;
  logic                   wr_en;
  logic [RW-1:0]          wr_addr;
  logic [MAX_COLUMNS-1:0] wr_data;

  // Derived sizes and decode.
  logic [NRW-1:0]         eff_rows;
  logic [NCW-1:0]         eff_cols;
  logic [MAX_COLUMNS-1:0] col_mask;
  logic [NRW-1:0]         new_rows;
  logic [MAX_COLUMNS-1:0] new_col_mask;
  logic [MAX_ROWS-1:0]    row_keep;
  logic                   cfg_rows_wr;
  logic                   cfg_cols_wr;
  logic                   accept;
  logic                   addr_in_range;
  logic                   cell_old;
  logic                   cell_new;
  logic [MAX_COLUMNS-1:0] below_row;
  logic                   gen_compute;
  logic                   gen_last;
  logic [MAX_COLUMNS-1:0] next_row;
  logic                   row_changed;

  assign eff_rows     = eff_rows_f(active_rows);
  assign eff_cols     = eff_cols_f(active_columns);
  assign col_mask     = col_mask_f(eff_cols);
  assign cfg_rows_wr  = cfg_write && (cfg_index == CFG_ACTIVE_ROWS);
  assign cfg_cols_wr  = cfg_write && (cfg_index == CFG_ACTIVE_COLUMNS);
  assign new_rows     = eff_rows_f(cfg_data[SIZE_W-1:0]);
  assign new_col_mask = col_mask_f(eff_cols_f(cfg_data[SIZE_W-1:0]));

  // Rows at or beyond a new row count lose their contents.
  always_comb begin
    for (int r = 0; r < MAX_ROWS; r++) begin
      row_keep[r] = (NRW'(r) < new_rows);
    end
  end

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign addr_in_range = (RAW'(cmd.row) < RAW'(eff_rows)) && (CAW'(cmd.column) < CAW'(eff_cols));

  // A row that was never written since reset or a shrink reads as all dead.
  assign rd_row   = rd_ok ? rd_data : '0;
  assign cell_old = rd_row[col_q];
  assign cell_new = cell_old ^ (op_q == OP_TOGGLE);

  // Generation sweep: at count k row k is read, row k-2 is written.
  assign below_row   = ((gen_cnt != '0) && (gen_cnt <= GW'(eff_rows))) ? rd_row : '0;
  assign gen_compute = (gen_cnt >= GW'(2));
  assign gen_last    = (gen_cnt == GW'(eff_rows) + GW'(1));

  lag_row_update #(
    .COLUMNS (MAX_COLUMNS)
  ) u_row_update (
    .above    (above_row),
    .current  (current_row),
    .below    (below_row),
    .keep     (col_mask),
    .rule     (rule),
    .next_row (next_row),
    .changed  (row_changed)
  );

  // Memory port control for each state.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = RW'(cmd.row);
    wr_en   = 1'b0;
    wr_addr = row_q;
    wr_data = rd_row;
    case (state)
      ST_IDLE: begin
        rd_en   = accept && (cmd.op != OP_GEN) && addr_in_range;
        rd_addr = RW'(cmd.row);
      end
      ST_ACCESS: begin
        wr_en            = (op_q == OP_TOGGLE);
        wr_addr          = row_q;
        wr_data          = rd_row;
        wr_data[col_q]   = cell_new;
      end
      ST_GEN: begin
        rd_en   = (gen_cnt < GW'(eff_rows));
        rd_addr = RW'(gen_cnt);
        wr_en   = gen_compute;
        wr_addr = RW'(gen_cnt - GW'(2));
        wr_data = next_row;
      end
      ST_CLEAR: begin
        rd_en   = (gen_cnt < GW'(MAX_ROWS));
        rd_addr = RW'(gen_cnt);
        wr_en   = (gen_cnt != '0);
        wr_addr = RW'(gen_cnt - GW'(1));
        wr_data = rd_row & sweep_mask;
      end
      default: begin
        rd_en = 1'b0;
        wr_en = 1'b0;
      end
    endcase
  end

  // Row memory: one registered read port and one write port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= grid_mem[rd_addr];
      rd_ok   <= row_valid[rd_addr];
    end
    if (wr_en) begin
      grid_mem[wr_addr] <= wr_data;
    end
  end

  // Valid bits: set on write, cleared for rows dropped by a row count write.
  always_comb begin
    row_valid_next = row_valid;
    if (wr_en) begin
      row_valid_next[wr_addr] = 1'b1;
    end
    if (cfg_rows_wr) begin
      row_valid_next = row_valid_next & row_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else begin
      row_valid <= row_valid_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_rows      <= RST_ACTIVE_ROWS;
      active_columns   <= RST_ACTIVE_COLUMNS;
      rule.birth_count <= RST_BIRTH_COUNT;
      rule.survive_min <= RST_SURVIVE_MIN;
      rule.survive_max <= RST_SURVIVE_MAX;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ACTIVE_ROWS:    active_rows      <= cfg_data[SIZE_W-1:0];
        CFG_ACTIVE_COLUMNS: active_columns   <= cfg_data[SIZE_W-1:0];
        CFG_BIRTH_COUNT:    rule.birth_count <= cfg_data[RULE_W-1:0];
        CFG_SURVIVE_MIN:    rule.survive_min <= cfg_data[RULE_W-1:0];
        CFG_SURVIVE_MAX:    rule.survive_max <= cfg_data[RULE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      gen_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (cmd.op == OP_GEN) begin
              state   <= ST_GEN;
              gen_cnt <= '0;
            end else if (addr_in_range) begin
              state <= ST_ACCESS;
            end else begin
              done <= 1'b1;
            end
          end
        end
        ST_ACCESS: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        ST_GEN: begin
          gen_cnt <= gen_cnt + GW'(1);
          if (gen_last) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        ST_CLEAR: begin
          gen_cnt <= gen_cnt + GW'(1);
          if (gen_cnt == GW'(MAX_ROWS)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // A column count write restarts the clearing sweep from the first row.
      if (cfg_cols_wr) begin
        state   <= ST_CLEAR;
        gen_cnt <= '0;
      end
    end
  end

  // Sequencer data: command fields, row window, stability flag and result.
  always_ff @(posedge clk) begin
    if (accept && (state == ST_IDLE)) begin
      op_q        <= cmd.op;
      row_q       <= RW'(cmd.row);
      col_q       <= CW'(cmd.column);
      above_row   <= '0;
      current_row <= '0;
      same        <= 1'b1;
      result      <= '{cell_alive: 1'b0, stable: 1'b0,
                       out_of_range: (cmd.op != OP_GEN) && !addr_in_range};
    end
    if (state == ST_ACCESS) begin
      result <= '{cell_alive: cell_new, stable: 1'b0, out_of_range: 1'b0};
    end
    if (state == ST_GEN) begin
      if (gen_cnt != '0) begin
        above_row   <= current_row;
        current_row <= below_row;
      end
      if (gen_compute) begin
        same <= same & ~row_changed;
      end
      if (gen_last) begin
        result <= '{cell_alive: 1'b0, stable: same & ~row_changed, out_of_range: 1'b0};
      end
    end
    // Sweeps that overlap keep clearing every column that any of them dropped.
    if (cfg_cols_wr) begin
      sweep_mask <= (state == ST_CLEAR) ? (sweep_mask & new_col_mask) : new_col_mask;
    end
  end

`ifndef ASSERT_OFF
  // An address outside the active area reports nothing else.
  assert property (@(posedge clk) disable iff (rst)
    done && result.out_of_range |-> !result.cell_alive && !result.stable)
    else $error("out of range result carries cell or stable flag");

  // During a generation the row written never collides with the row read.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_GEN) && rd_en && wr_en |-> (rd_addr != wr_addr))
    else $error("generation sweep reads and writes the same row");

  // A generation command starts the sweep from its first row.
  assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.op == OP_GEN) && !cfg_cols_wr |=> (state == ST_GEN) && (gen_cnt == '0))
    else $error("generation did not start its sweep");

  // A column count write always begins a fresh clearing sweep.
  assert property (@(posedge clk) disable iff (rst)
    cfg_cols_wr |=> (state == ST_CLEAR) && (gen_cnt == '0))
    else $error("column resize did not start the clearing sweep");
`endif

endmodule

// File: rtl/core/lag_row_update.sv
// Next-generation logic for one grid row from the old rows above, at and below it.
// Depends on lag_pkg for the rule struct and the neighbor count width.
module lag_row_update
  import lag_pkg::*;
#(
  parameter int COLUMNS = LAG_MAX_COLUMNS
) (
  input  logic [COLUMNS-1:0] above,
  input  logic [COLUMNS-1:0] current,
  input  logic [COLUMNS-1:0] below,
  input  logic [COLUMNS-1:0] keep,
  input  rule_t              rule,
  output logic [COLUMNS-1:0] next_row,
  output logic               changed
);

  logic [COLUMNS+1:0] above_pad;
  logic [COLUMNS+1:0] current_pad;
  logic [COLUMNS+1:0] below_pad;

  // Zero padding on both sides makes the edge columns see dead neighbors.
  assign above_pad   = {1'b0, above, 1'b0};
  assign current_pad = {1'b0, current, 1'b0};
  assign below_pad   = {1'b0, below, 1'b0};

  // Count the eight neighbors of every cell and apply the rule.
  always_comb begin
    logic [COUNT_W-1:0] count;
    logic               alive;
    next_row = '0;
    for (int c = 0; c < COLUMNS; c++) begin
      count = COUNT_W'(above_pad[c]) + COUNT_W'(above_pad[c+1]) + COUNT_W'(above_pad[c+2])
            + COUNT_W'(current_pad[c]) + COUNT_W'(current_pad[c+2])
            + COUNT_W'(below_pad[c]) + COUNT_W'(below_pad[c+1]) + COUNT_W'(below_pad[c+2]);
      if (current[c]) begin
        alive = (count >= rule.survive_min) && (count <= rule.survive_max);
      end else begin
        alive = (count == rule.birth_count);
      end
      // Cells outside the active columns stay dead.
      next_row[c] = alive & keep[c];
    end
  end

  assign changed = |((next_row ^ current) & keep);

endmodule

// File: dv/grid_tracker_pkg.sv
`timescale 1ns / 100ps
// Cell grid tracker for the life automaton testbench: keeps its own copy of the grid
// and registers, predicts each command's result and checks result transfers. Needs lag_pkg.
package grid_tracker_pkg;
  import lag_pkg::*;

  class grid_tracker;
    bit [LAG_MAX_COLUMNS-1:0] cells [LAG_MAX_ROWS];
    int rows_reg;
    int cols_reg;
    int birth;
    int keep_min;
    int keep_max;
    result_t due[$];
    int faults;

    function new();
      rows_reg = RST_ACTIVE_ROWS;
      cols_reg = RST_ACTIVE_COLUMNS;
      birth    = RST_BIRTH_COUNT;
      keep_min = RST_SURVIVE_MIN;
      keep_max = RST_SURVIVE_MAX;
      foreach (cells[r]) cells[r] = '0;
      faults = 0;
    endfunction

    // A size register of zero acts as one; larger values saturate at the grid size.
    function int span(int value, int cap);
      if (value == 0) return 1;
      return (value > cap) ? cap : value;
    endfunction

    function int span_rows();
      return span(rows_reg, LAG_MAX_ROWS);
    endfunction

    function int span_columns();
      return span(cols_reg, LAG_MAX_COLUMNS);
    endfunction

    // Register write. Cells outside the active area are kept dead, so a resize clears them.
    function void apply_config(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      int nr;
      int nc;
      case (index)
        CFG_ACTIVE_ROWS:    rows_reg = int'(data);
        CFG_ACTIVE_COLUMNS: cols_reg = int'(data);
        CFG_BIRTH_COUNT:    birth    = int'(data[RULE_W-1:0]);
        CFG_SURVIVE_MIN:    keep_min = int'(data[RULE_W-1:0]);
        CFG_SURVIVE_MAX:    keep_max = int'(data[RULE_W-1:0]);
        default: ;
      endcase
      nr = span_rows();
      nc = span_columns();
      for (int r = 0; r < LAG_MAX_ROWS; r++) begin
        for (int c = 0; c < LAG_MAX_COLUMNS; c++) begin
          if (r >= nr || c >= nc) cells[r][c] = 1'b0;
        end
      end
    endfunction

    // One generation: every active cell is updated from the old grid. Neighbours outside
    // the active area count as dead, so nothing wraps. Returns 1 if no cell changed.
    function bit sweep_generation();
      bit [LAG_MAX_COLUMNS-1:0] prior [LAG_MAX_ROWS];
      int nr;
      int nc;
      int n;
      int rr;
      int cc;
      bit fresh;
      bit unchanged;
      prior = cells;
      nr = span_rows();
      nc = span_columns();
      unchanged = 1'b1;
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < nc; c++) begin
          n = 0;
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              rr = r + dr;
              cc = c + dc;
              if ((dr != 0 || dc != 0) && rr >= 0 && rr < nr && cc >= 0 && cc < nc)
                n += prior[rr][cc];
            end
          end
          // Rule bounds are compared as written, so a birth count or survive minimum above eight never matches.
          if (prior[r][c]) fresh = (n >= keep_min && n <= keep_max);
          else fresh = (n == birth);
          if (fresh != prior[r][c]) unchanged = 1'b0;
          cells[r][c] = fresh;
        end
      end
      return unchanged;
    endfunction

    // Note an accepted command transfer and queue the result it must produce.
    function void log_command(cmd_t item);
      result_t want;
      want = '0;
      if (item.op == OP_GEN) begin
        want.stable = sweep_generation();
      end else if (item.row >= span_rows() || item.column >= span_columns()) begin
        want.out_of_range = 1'b1;
      end else begin
        // Every code other than toggle and generation reads the cell.
        if (item.op == OP_TOGGLE) cells[item.row][item.column] = ~cells[item.row][item.column];
        want.cell_alive = cells[item.row][item.column];
      end
      due = {due, want};
    endfunction

    // Check one result transfer against the oldest outstanding prediction.
    function void compare_result(result_t got);
      result_t want;
      if (due.size() == 0) begin
        $error("result transfer with nothing outstanding: %b", got);
        faults++;
        return;
      end
      want = due.pop_front();
      if (got.cell_alive !== want.cell_alive) begin
        $error("cell_alive: expected %0b, actual %0b", want.cell_alive, got.cell_alive);
        faults++;
      end
      if (got.stable !== want.stable) begin
        $error("stable: expected %0b, actual %0b", want.stable, got.stable);
        faults++;
      end
      if (got.out_of_range !== want.out_of_range) begin
        $error("out_of_range: expected %0b, actual %0b", want.out_of_range, got.out_of_range);
        faults++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction

    // Results still outstanding at the end count as failures.
    function int close_out();
      if (due.size() != 0) begin
        $error("%0d result transfers never arrived", due.size());
        faults += due.size();
      end
      return faults;
    endfunction
  endclass

endpackage

// File: dv/tb.sv
`timescale 1ns / 100ps
// Top-level testbench for life_automaton_generation: directed and random commands with
// bursty pacing, register phases at the extremes. Needs lag_pkg and grid_tracker_pkg.
module tb;
  import lag_pkg::*;
  import grid_tracker_pkg::*;

  // Read codes; any code other than toggle or generation reads the cell.
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int PHASE_ITEMS = 52;
  localparam int DRAIN_CYCLES = LAG_MAX_ROWS + 16;
  localparam int CMD_W = $bits(cmd_t);

  logic                   clk;
  logic                   rst;
  logic                   start;
  cmd_t                   cmd;
  logic                   busy;
  logic                   done;
  result_t                result;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  grid_tracker board;

  life_automaton_generation i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock with an 8 ns period.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Result transfers cannot be held off; check each one at the edge that ends it.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) board.compare_result(result);
  end

  // Hard limit on the run.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic cmd_t mk(logic [OP_W-1:0] op, int row, int column);
    cmd_t item;
    item.op     = op;
    item.row    = ROW_W'(row);
    item.column = COL_W'(column);
    return item;
  endfunction

  // Present a command and hold it until the transfer; start stays high afterwards.
  task automatic issue(cmd_t item);
    start <= 1'b1;
    cmd   <= item;
    do @(posedge clk); while (busy !== 1'b0);
    board.log_command(item);
  endtask

  // Drop start and wait until every result has come back and the block is idle.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (board.pending() != 0 || busy !== 1'b0);
  endtask

  // One register write, then wait out any clearing sweep it starts.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    board.apply_config(index, data);
    cfg_write <= 1'b0;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // Full register setting; the column write comes last since it starts a sweep.
  task automatic configure(int rows, int cols, int birth, int keep_min, int keep_max);
    write_reg(CFG_ACTIVE_ROWS, CFG_DATA_W'(rows));
    write_reg(CFG_BIRTH_COUNT, CFG_DATA_W'(birth));
    write_reg(CFG_SURVIVE_MIN, CFG_DATA_W'(keep_min));
    write_reg(CFG_SURVIVE_MAX, CFG_DATA_W'(keep_max));
    write_reg(CFG_ACTIVE_COLUMNS, CFG_DATA_W'(cols));
  endtask

  // Hand-picked commands: corners, every code, a blinker, a corner block, out of range.
  task automatic run_directed();
    issue(mk(OP_TOGGLE, 0, 0));
    issue(mk(OP_READ, 0, 0));
    issue(mk(OP_TOGGLE, 63, 63));
    issue(mk(OP_SPARE, 63, 63));
    issue(mk(OP_GEN, 0, 0));
    issue(mk(OP_GEN, 63, 63));
    issue(mk(OP_TOGGLE, 10, 9));
    issue(mk(OP_TOGGLE, 10, 10));
    issue(mk(OP_TOGGLE, 10, 11));
    issue(mk(OP_GEN, 0, 0));
    issue(mk(OP_READ, 9, 10));
    issue(mk(OP_READ, 10, 9));
    issue(mk(OP_GEN, 0, 0));
    issue(mk(OP_TOGGLE, 62, 62));
    issue(mk(OP_TOGGLE, 62, 63));
    issue(mk(OP_TOGGLE, 63, 62));
    issue(mk(OP_TOGGLE, 63, 63));
    issue(mk(OP_GEN, 0, 0));
    issue(mk(OP_TOGGLE, 0, 63));
    issue(mk(OP_READ, 63, 0));
    settle();
    // Shrink the grid: everything outside three rows by five columns is cleared.
    configure(3, 5, 3, 2, 3);
    issue(mk(OP_TOGGLE, 3, 0));
    issue(mk(OP_READ, 0, 5));
    issue(mk(OP_SPARE, 63, 63));
    issue(mk(OP_TOGGLE, 2, 4));
    issue(mk(OP_GEN, 0, 0));
    settle();
  endtask

  // Random commands, mostly inside the active area, sent in bursts with random gaps.
  task automatic run_random(int count);
    cmd_t item;
    int pick;
    int burst;
    int gap;
    burst = $urandom_range(1, 8);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      item.op = (pick < 45) ? OP_TOGGLE : (pick < 70) ? OP_READ : (pick < 75) ? OP_SPARE : OP_GEN;
      if ($urandom_range(0, 99) < 85) begin
        item.row    = ROW_W'($urandom_range(0, board.span_rows() - 1));
        item.column = COL_W'($urandom_range(0, board.span_columns() - 1));
      end else begin
        item.row    = ROW_W'($urandom_range(0, (1 << ROW_W) - 1));
        item.column = COL_W'($urandom_range(0, (1 << COL_W) - 1));
      end
      issue(item);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 8);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          start <= 1'b0;
          cmd   <= cmd_t'(CMD_W'($urandom));
          repeat (gap) @(posedge clk);
        end
      end
    end
    settle();
  endtask

  // Register settings per phase: rows, columns, birth, survive min, survive max.
  int plan [9][5] = '{
    '{8, 8, 3, 2, 3},
    '{0, 64, 3, 2, 3},
    '{127, 0, 2, 0, 8},
    '{5, 7, 0, 3, 2},
    '{16, 12, 15, 0, 15},
    '{64, 64, 3, 2, 3},
    '{3, 3, 1, 1, 4},
    '{1, 127, 8, 8, 8},
    '{12, 20, 3, 2, 3}
  };

  // Main sequence: reset, directed part, then one random phase per register setting.
  initial begin
    int failures;
    board     = new();
    rst       = 1'b1;
    start     = 1'b0;
    cmd       = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    foreach (plan[p]) begin
      // The last phase draws its rule at random.
      if (p == 8) begin
        plan[p][2] = $urandom_range(0, 8);
        plan[p][3] = $urandom_range(0, 8);
        plan[p][4] = $urandom_range(0, 8);
      end
      configure(plan[p][0], plan[p][1], plan[p][2], plan[p][3], plan[p][4]);
      run_random(PHASE_ITEMS);
    end

    // Watch for stray result transfers before the verdict.
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    failures = board.close_out();
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
